### design/msfhd_pkg.sv
`timescale 1ns / 1ps

package msfhd_pkg;

  // signed integer speed in percent and signed q7.8 filtered speed
  typedef logic signed [7:0]  speed_t;
  typedef logic signed [15:0] fspeed_t;

  // filter coefficient in q1.8
  typedef logic [8:0] coef_t;
  typedef logic [6:0] duty_t;

  localparam int FRAC_BITS = 8;
  localparam int NUM_CH    = 3;

  localparam coef_t COEF_ONE  = 9'd256;
  localparam speed_t SPEED_MIN = -8'sd100;
  localparam speed_t SPEED_MAX = 8'sd100;
  localparam duty_t DUTY_FULL = 7'd100;

  // operation codes
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // channel codes
  localparam logic [1:0] CH_LEFT   = 2'd0;
  localparam logic [1:0] CH_RIGHT  = 2'd1;
  localparam logic [1:0] CH_CANNON = 2'd2;

  // configuration register indexes
  localparam logic REG_FILTER_COEF = 1'b0;
  localparam logic REG_PWM_MAX     = 1'b1;

  localparam coef_t COEF_RESET    = 9'd26;
  localparam duty_t PWM_MAX_RESET = 7'd100;

endpackage

### design/msfhd_filter.sv
`timescale 1ns / 1ps

module msfhd_filter (
  input  msfhd_pkg::speed_t  target,
  input  msfhd_pkg::fspeed_t filtered,
  input  msfhd_pkg::coef_t   coef,
  output msfhd_pkg::fspeed_t filtered_next,
  output msfhd_pkg::speed_t  whole
);

  logic signed [16:0] target_q;
  logic signed [16:0] diff;
  logic signed [26:0] prod;
  logic signed [26:0] prod_rnd;
  logic signed [18:0] step;
  logic signed [19:0] sum;
  logic               frac_nz;

  // error between target and filtered value, scaled by the coefficient
  always_comb begin
    target_q = 17'($signed({target, 8'b0}));
    diff     = target_q - 17'(filtered);
    prod     = 27'(diff) * $signed({18'b0, coef});
  end

  // step rounded away from zero
  always_comb begin
    prod_rnd = prod[26] ? prod : prod + 27'sd255;
    step     = prod_rnd[26:msfhd_pkg::FRAC_BITS];
    sum      = 20'(filtered) + 20'(step);
  end

  // saturate to the q7.8 range
  always_comb begin
    if (sum > 20'sd32767) begin
      filtered_next = 16'sh7fff;
    end else if (sum < -20'sd32768) begin
      filtered_next = 16'sh8000;
    end else begin
      filtered_next = sum[15:0];
    end
  end

  // integer part truncated toward zero
  always_comb begin
    frac_nz = |filtered_next[7:0];
    if (filtered_next[15] && frac_nz) begin
      whole = filtered_next[15:8] + 8'sd1;
    end else begin
      whole = filtered_next[15:8];
    end
  end

endmodule

### design/motor_speed_filter_hbridge_drive_top.sv
`timescale 1ns / 1ps
// a tick item goes from the input register to the result register; the three channel filters
// update in one pass per tick; one item per cycle unless a tick waits for a full result slot
// set items update the target of at most one channel (none for channel code 3) and give no result
// reset (rst, synchronous): targets and filtered speeds to zero, filter_coef 26, pwm_max 100,
// both stream stages empty

module motor_speed_filter_hbridge_drive_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] speed_request
  input  logic [2:0]  s_axis_tuser,   // [0] operation, [2:1] motor_select
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] bridge_enable_duty, [13:7] left_forward_duty, [20:14] left_reverse_duty,
  // [27:21] right_forward_duty, [34:28] right_reverse_duty, [41:35] cannon_duty, [47:42] zero
  output logic [47:0] m_axis_tdata,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  // configuration registers
  msfhd_pkg::coef_t filter_coef;
  msfhd_pkg::duty_t pwm_max;

  // input register
  logic              in_valid;
  logic              in_op;
  logic [1:0]        in_sel;
  msfhd_pkg::speed_t in_req;

  // channel state
  msfhd_pkg::speed_t  target_speed   [msfhd_pkg::NUM_CH];
  msfhd_pkg::fspeed_t filtered_speed [msfhd_pkg::NUM_CH];
  msfhd_pkg::fspeed_t filtered_next  [msfhd_pkg::NUM_CH];
  msfhd_pkg::speed_t  whole          [msfhd_pkg::NUM_CH];

  // result register
  msfhd_pkg::duty_t bridge_duty;
  msfhd_pkg::duty_t left_fwd;
  msfhd_pkg::duty_t left_rev;
  msfhd_pkg::duty_t right_fwd;
  msfhd_pkg::duty_t right_rev;
  msfhd_pkg::duty_t cannon;

  logic               advance;
  msfhd_pkg::coef_t   coef_eff;
  msfhd_pkg::speed_t  track_req;
  msfhd_pkg::speed_t  cannon_req;
  msfhd_pkg::duty_t   bridge_next;
  msfhd_pkg::duty_t   left_fwd_next;
  msfhd_pkg::duty_t   left_rev_next;
  msfhd_pkg::duty_t   right_fwd_next;
  msfhd_pkg::duty_t   right_rev_next;
  msfhd_pkg::duty_t   cannon_next;

  function automatic msfhd_pkg::duty_t duty_of(logic signed [9:0] v, msfhd_pkg::duty_t lim);
    logic signed [9:0] lim_s;
    lim_s = $signed({3'b0, lim});
    if (v[9]) begin
      duty_of = '0;
    end else if (v > lim_s) begin
      duty_of = lim;
    end else begin
      duty_of = v[6:0];
    end
  endfunction

  // the item in the input register moves on unless a tick waits for a full result slot
  assign advance       = in_valid && (in_op == msfhd_pkg::OP_SET || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_coef <= msfhd_pkg::COEF_RESET;
      pwm_max     <= msfhd_pkg::PWM_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        msfhd_pkg::REG_FILTER_COEF: filter_coef <= cfg_data;
        msfhd_pkg::REG_PWM_MAX:     pwm_max     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op  <= s_axis_tuser[0];
      in_sel <= s_axis_tuser[2:1];
      in_req <= s_axis_tdata;
    end
  end

  // coefficients above one act as one
  assign coef_eff = (filter_coef > msfhd_pkg::COEF_ONE) ? msfhd_pkg::COEF_ONE : filter_coef;

  // per-channel clamping of the requested speed
  always_comb begin
    if (in_req < msfhd_pkg::SPEED_MIN) begin
      track_req = msfhd_pkg::SPEED_MIN;
    end else if (in_req > msfhd_pkg::SPEED_MAX) begin
      track_req = msfhd_pkg::SPEED_MAX;
    end else begin
      track_req = in_req;
    end
    if (in_req[7]) begin
      cannon_req = '0;
    end else if (in_req > msfhd_pkg::SPEED_MAX) begin
      cannon_req = msfhd_pkg::SPEED_MAX;
    end else begin
      cannon_req = in_req;
    end
  end

  // one low-pass filter per channel
  for (genvar ch = 0; ch < msfhd_pkg::NUM_CH; ch++) begin : g_filter
    msfhd_filter u_filter (
      .target        (target_speed[ch]),
      .filtered      (filtered_speed[ch]),
      .coef          (coef_eff),
      .filtered_next (filtered_next[ch]),
      .whole         (whole[ch])
    );
  end

  // target and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < msfhd_pkg::NUM_CH; i++) begin
        target_speed[i]   <= '0;
        filtered_speed[i] <= '0;
      end
    end else if (advance) begin
      if (in_op == msfhd_pkg::OP_TICK) begin
        for (int i = 0; i < msfhd_pkg::NUM_CH; i++) begin
          filtered_speed[i] <= filtered_next[i];
        end
      end else begin
        case (in_sel)
          msfhd_pkg::CH_LEFT:   target_speed[0] <= track_req;
          msfhd_pkg::CH_RIGHT:  target_speed[1] <= track_req;
          msfhd_pkg::CH_CANNON: target_speed[2] <= cannon_req;
          default: ;
        endcase
      end
    end
  end

  // duties from the new filtered speeds, direction chosen by target sign
  always_comb begin
    if (target_speed[0] != 8'sd0 || target_speed[1] != 8'sd0) begin
      bridge_next = (pwm_max < msfhd_pkg::DUTY_FULL) ? pwm_max : msfhd_pkg::DUTY_FULL;
    end else begin
      bridge_next = '0;
    end
    if (target_speed[0] > 8'sd0) begin
      left_fwd_next = duty_of(10'(whole[0]), pwm_max);
      left_rev_next = '0;
    end else begin
      left_fwd_next = '0;
      left_rev_next = duty_of(-10'(whole[0]), pwm_max);
    end
    if (target_speed[1] > 8'sd0) begin
      right_fwd_next = duty_of(10'(whole[1]), pwm_max);
      right_rev_next = '0;
    end else begin
      right_fwd_next = '0;
      right_rev_next = duty_of(-10'(whole[1]), pwm_max);
    end
    cannon_next = duty_of(10'(whole[2]), pwm_max);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && in_op == msfhd_pkg::OP_TICK) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_op == msfhd_pkg::OP_TICK) begin
      bridge_duty <= bridge_next;
      left_fwd    <= left_fwd_next;
      left_rev    <= left_rev_next;
      right_fwd   <= right_fwd_next;
      right_rev   <= right_rev_next;
      cannon      <= cannon_next;
    end
  end

  assign m_axis_tdata = {6'b0, cannon, right_rev, right_fwd, left_rev, left_fwd, bridge_duty};

  // a tick that moves on always leaves a result behind
  assert property (@(posedge clk) disable iff (rst)
    advance && in_op == msfhd_pkg::OP_TICK |=> m_axis_tvalid)
    else $error("tick transfer produced no result");

  // a set item never creates a result
  assert property (@(posedge clk) disable iff (rst)
    advance && in_op == msfhd_pkg::OP_SET && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("set item produced a result");

  // forward and reverse are never driven together
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (left_fwd == '0 || left_rev == '0) && (right_fwd == '0 || right_rev == '0))
    else $error("forward and reverse duty both nonzero");

  // cannon target stays in its unidirectional range
  assert property (@(posedge clk) disable iff (rst)
    !target_speed[2][7] && target_speed[2] <= msfhd_pkg::SPEED_MAX)
    else $error("cannon target out of range");

  // a stalled item holds the input side
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |-> !s_axis_tready && m_axis_tvalid && !m_axis_tready)
    else $error("input stall without a blocked result");

endmodule

### verif/motor_speed_filter_hbridge_drive_top_tb.sv
`timescale 1ns / 1ps

module motor_speed_filter_hbridge_drive_top_tb;

  // the channel that set items may address but that holds no motor
  localparam logic [1:0] CH_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 1000;

  // duty predictor plus the queue of duty sets still owed by the block
  class drive_scoreboard;
    int target_pct[msfhd_pkg::NUM_CH];
    int filt_q78[msfhd_pkg::NUM_CH];
    int coef;
    int pwm_limit;
    logic [47:0] duty_q[$];
    int errors;

    function new();
      for (int ch = 0; ch < msfhd_pkg::NUM_CH; ch++) begin
        target_pct[ch] = 0;
        filt_q78[ch] = 0;
      end
      coef = int'(msfhd_pkg::COEF_RESET);
      pwm_limit = int'(msfhd_pkg::PWM_MAX_RESET);
      errors = 0;
    endfunction

    function int clip(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function msfhd_pkg::duty_t duty(int v);
      return msfhd_pkg::duty_t'(clip(v, 0, pwm_limit));
    endfunction

    // one low-pass step, step rounded away from zero
    function int filter_next(int f, int tgt, int c);
      int d;
      int s;
      d = (tgt * (1 << msfhd_pkg::FRAC_BITS) - f) * c;
      if (d >= 0) s = (d + 255) / 256;
      else s = -((-d + 255) / 256);
      return clip(f + s, -32768, 32767);
    endfunction

    function string field_name(int i);
      case (i)
        0: return "bridge_enable_duty";
        1: return "left_forward_duty";
        2: return "left_reverse_duty";
        3: return "right_forward_duty";
        4: return "right_reverse_duty";
        default: return "cannon_duty";
      endcase
    endfunction

    function void write_reg(logic idx, logic [8:0] v);
      if (idx == msfhd_pkg::REG_FILTER_COEF) coef = int'(v);
      else pwm_limit = int'(v[6:0]);
    endfunction

    function int pending();
      return duty_q.size();
    endfunction

    // accepted input transfer: store a target or predict a tick's duties
    function void note_item(logic op, logic [1:0] sel, logic [7:0] spd);
      int req;
      int c;
      int whole;
      logic [47:0] res;
      req = int'($signed(spd));
      if (op == msfhd_pkg::OP_SET) begin
        if (sel == msfhd_pkg::CH_LEFT || sel == msfhd_pkg::CH_RIGHT)
          target_pct[sel] = clip(req, int'(msfhd_pkg::SPEED_MIN), int'(msfhd_pkg::SPEED_MAX));
        else if (sel == msfhd_pkg::CH_CANNON)
          target_pct[msfhd_pkg::CH_CANNON] = clip(req, 0, int'(msfhd_pkg::SPEED_MAX));
        return;
      end
      res = '0;
      if (target_pct[msfhd_pkg::CH_LEFT] != 0 || target_pct[msfhd_pkg::CH_RIGHT] != 0)
        res[6:0] = duty(int'(msfhd_pkg::DUTY_FULL));
      c = (coef > int'(msfhd_pkg::COEF_ONE)) ? int'(msfhd_pkg::COEF_ONE) : coef;
      for (int ch = 0; ch < msfhd_pkg::NUM_CH; ch++)
        filt_q78[ch] = filter_next(filt_q78[ch], target_pct[ch], c);
      // tracks: direction follows the sign of the target
      for (int ch = 0; ch < 2; ch++) begin
        whole = filt_q78[ch] / (1 << msfhd_pkg::FRAC_BITS);
        if (target_pct[ch] > 0) res[7 + 14 * ch +: 7] = duty(whole);
        else res[14 + 14 * ch +: 7] = duty(-whole);
      end
      res[35 +: 7] = duty(filt_q78[msfhd_pkg::CH_CANNON] / (1 << msfhd_pkg::FRAC_BITS));
      duty_q.push_back(res);
    endfunction

    // accepted result transfer against the oldest predicted duty set
    function void check_result(logic [47:0] got);
      logic [47:0] want;
      if (duty_q.size() == 0) begin
        $error("result transfer with no tick outstanding: %h", got);
        errors++;
        return;
      end
      want = duty_q.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (got[7 * i +: 7] !== want[7 * i +: 7]) begin
          $error("%s: expected %0d, got %0d", field_name(i), want[7 * i +: 7],
                 got[7 * i +: 7]);
          errors++;
        end
      end
      if (got[47:42] !== 6'd0) begin
        $error("tdata padding: expected 0, got %h", got[47:42]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [8:0]  cfg_data;

  drive_scoreboard sb = new();
  bit quiet;
  bit hold_req;
  int stall_count;

  motor_speed_filter_hbridge_drive_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transfer monitor on both streams
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(s_axis_tuser[0], s_axis_tuser[2:1], s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("motor_speed_filter_hbridge_drive_top_tb: FAIL");
      $finish;
    end
  end

  // result receiver: random stall bursts and one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // one input transfer, with an occasional idle burst ahead of it
  task automatic send_item(logic op, logic [1:0] sel, logic [7:0] spd);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = {sel, op};
    s_axis_tdata = spd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // drop valid, let every tick drain, then give the pipeline time to empty
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [8:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_filter(logic [8:0] coef_val, logic [8:0] pwm_val);
    cfg_write(msfhd_pkg::REG_FILTER_COEF, coef_val);
    cfg_write(msfhd_pkg::REG_PWM_MAX, pwm_val);
  endtask

  // random mix of target updates and ticks, mostly in range speeds
  task automatic run_random(int n, int tick_pct);
    logic op;
    logic [1:0] sel;
    logic [7:0] spd;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < tick_pct) ? msfhd_pkg::OP_TICK : msfhd_pkg::OP_SET;
      sel = ($urandom_range(0, 7) == 0) ? CH_UNUSED : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 3) != 0) spd = 8'($signed($urandom_range(0, 200)) - 100);
      else spd = 8'($urandom);
      send_item(op, sel, spd);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = msfhd_pkg::REG_FILTER_COEF;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, clamps, ignored channel, tick fields ignored
    send_item(msfhd_pkg::OP_TICK, msfhd_pkg::CH_LEFT, 8'h00);
    send_item(msfhd_pkg::OP_SET, msfhd_pkg::CH_LEFT, 8'h7f);
    send_item(msfhd_pkg::OP_SET, msfhd_pkg::CH_RIGHT, 8'h80);
    send_item(msfhd_pkg::OP_SET, msfhd_pkg::CH_CANNON, 8'h7f);
    send_item(msfhd_pkg::OP_SET, CH_UNUSED, 8'h37);
    send_item(msfhd_pkg::OP_TICK, CH_UNUSED, 8'haa);
    send_item(msfhd_pkg::OP_TICK, msfhd_pkg::CH_CANNON, 8'h55);
    send_item(msfhd_pkg::OP_TICK, msfhd_pkg::CH_RIGHT, 8'hff);
    send_item(msfhd_pkg::OP_SET, msfhd_pkg::CH_CANNON, 8'hff);
    send_item(msfhd_pkg::OP_TICK, msfhd_pkg::CH_LEFT, 8'h80);
    // targets back to zero while the filtered speeds are still away from it
    send_item(msfhd_pkg::OP_SET, msfhd_pkg::CH_LEFT, 8'h00);
    send_item(msfhd_pkg::OP_SET, msfhd_pkg::CH_RIGHT, 8'h00);
    send_item(msfhd_pkg::OP_TICK, msfhd_pkg::CH_LEFT, 8'h00);
    send_item(msfhd_pkg::OP_SET, msfhd_pkg::CH_LEFT, 8'h9c);
    send_item(msfhd_pkg::OP_SET, msfhd_pkg::CH_RIGHT, 8'h64);
    send_item(msfhd_pkg::OP_SET, msfhd_pkg::CH_CANNON, 8'h64);
    send_item(msfhd_pkg::OP_TICK, msfhd_pkg::CH_LEFT, 8'h00);
    send_item(msfhd_pkg::OP_SET, msfhd_pkg::CH_CANNON, 8'h80);
    send_item(msfhd_pkg::OP_TICK, msfhd_pkg::CH_LEFT, 8'h00);
    settle();

    // coefficient of one: filtered speed jumps straight to target
    set_filter(9'd256, 9'd127);
    send_item(msfhd_pkg::OP_SET, msfhd_pkg::CH_LEFT, 8'h01);
    send_item(msfhd_pkg::OP_SET, msfhd_pkg::CH_RIGHT, 8'hff);
    send_item(msfhd_pkg::OP_TICK, msfhd_pkg::CH_LEFT, 8'h00);
    run_random(50, 45);
    settle();

    // coefficient zero freezes the filter, upper cfg bits on pwm_max
    set_filter(9'd0, 9'h1ff);
    run_random(40, 40);
    settle();

    // coefficient above one acts as one, all duties forced to zero
    set_filter(9'd511, 9'd0);
    run_random(40, 40);
    settle();

    // long receiver hold-off so the block fills and stalls its input
    set_filter(9'd3, 9'd40);
    hold_req = 1'b1;
    run_random(60, 85);
    settle();

    for (int p = 0; p < 2; p++) begin
      set_filter(9'($urandom_range(0, 511)), 9'($urandom_range(0, 127)));
      run_random(60, 40);
      settle();
    end

    // back to reset values with no idling at all
    set_filter(msfhd_pkg::COEF_RESET, 9'(msfhd_pkg::PWM_MAX_RESET));
    quiet = 1'b1;
    run_random(80, 40);
    settle();

    if (sb.errors == 0)
      $display("motor_speed_filter_hbridge_drive_top_tb: PASS");
    else
      $display("motor_speed_filter_hbridge_drive_top_tb: FAIL");
    $finish;
  end

endmodule
